@@ sv/dedup_fifo_with_key_lists_assert.svh @@
// assertion macros used by the rtl file dfkl_ctrl.sv
`ifndef DEDUP_FIFO_WITH_KEY_LISTS_ASSERT_SVH
`define DEDUP_FIFO_WITH_KEY_LISTS_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DFKL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dfkl assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DFKL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dfkl assertion failed");

`endif

@@ sv/dfkl_pkg.sv @@
`default_nettype none

package dfkl_pkg;

	// fixed field widths
	localparam int OP_W     = 1;
	localparam int LETTER_W = 8;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 5;
	localparam int KCNT_W   = 4;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
	localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_NEW      = 3'd0,
		STAT_APPENDED = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_REMOVED  = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// write enables for the entry memory
	typedef struct packed {
		logic letter_en;
		logic count_en;
	} entry_wr_t;

endpackage

`default_nettype wire

@@ sv/dfkl_entry_mem.sv @@
`default_nettype none

module dfkl_entry_mem #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int KEYS_PER_ENTRY = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 rd_en,
	input  wire logic [$clog2(QUEUE_DEPTH)-1:0]       rd_addr,
	output logic      [dfkl_pkg::LETTER_W-1:0]        rd_letter,
	output logic      [$clog2(KEYS_PER_ENTRY+1)-1:0]  rd_count,
	input  wire dfkl_pkg::entry_wr_t                  wr,
	input  wire logic [$clog2(QUEUE_DEPTH)-1:0]       wr_addr,
	input  wire logic [dfkl_pkg::LETTER_W-1:0]        wr_letter,
	input  wire logic [$clog2(KEYS_PER_ENTRY+1)-1:0]  wr_count
);
	import dfkl_pkg::*;

	localparam int KW = $clog2(KEYS_PER_ENTRY + 1);

	// letters and key counts per slot; only live slots are ever read
	logic [LETTER_W-1:0] letter_mem [QUEUE_DEPTH];
	logic [KW-1:0]       count_mem  [QUEUE_DEPTH];
	logic [LETTER_W-1:0] rd_letter_q;
	logic [KW-1:0]       rd_count_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.letter_en) begin
			letter_mem[wr_addr] <= wr_letter;
		end
		if (wr.count_en) begin
			count_mem[wr_addr] <= wr_count;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_letter_q <= letter_mem[rd_addr];
			rd_count_q  <= count_mem[rd_addr];
		end
	end

	assign rd_letter = rd_letter_q;
	assign rd_count  = rd_count_q;

endmodule

`default_nettype wire

@@ sv/dfkl_key_mem.sv @@
`default_nettype none

module dfkl_key_mem #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int KEYS_PER_ENTRY = 8
) (
	input  wire logic                                            clk,
	input  wire logic                                            wr_en,
	input  wire logic [$clog2(QUEUE_DEPTH*KEYS_PER_ENTRY)-1:0]   wr_addr,
	input  wire logic signed [dfkl_pkg::KEY_W-1:0]               wr_data
);
	import dfkl_pkg::*;

	localparam int KEY_DEPTH = QUEUE_DEPTH * KEYS_PER_ENTRY;

	// key lists, one row of KEYS_PER_ENTRY slots per queue entry
	logic signed [KEY_W-1:0] key_mem [KEY_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ sv/dfkl_ctrl.sv @@
`default_nettype none

module dfkl_ctrl #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int KEYS_PER_ENTRY = 8
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	// input channel
	input  wire logic                                           in_valid,
	output logic                                                in_stall,
	input  wire logic [dfkl_pkg::OP_W-1:0]                      op,
	input  wire logic [dfkl_pkg::LETTER_W-1:0]                  letter,
	input  wire logic signed [dfkl_pkg::KEY_W-1:0]              key_value,
	// output channel
	output logic                                                out_valid,
	input  wire logic                                           out_stall,
	output logic      [dfkl_pkg::STATUS_W-1:0]                  status,
	output logic      [dfkl_pkg::LEN_W-1:0]                     queue_length,
	output logic      [dfkl_pkg::KCNT_W-1:0]                    entry_key_count,
	// entry memory
	output logic                                                rd_en,
	output logic      [$clog2(QUEUE_DEPTH)-1:0]                 rd_addr,
	input  wire logic [dfkl_pkg::LETTER_W-1:0]                  rd_letter,
	input  wire logic [$clog2(KEYS_PER_ENTRY+1)-1:0]            rd_count,
	output dfkl_pkg::entry_wr_t                                 entry_wr,
	output logic      [$clog2(QUEUE_DEPTH)-1:0]                 entry_wr_addr,
	output logic      [dfkl_pkg::LETTER_W-1:0]                  entry_wr_letter,
	output logic      [$clog2(KEYS_PER_ENTRY+1)-1:0]            entry_wr_count,
	// key memory
	output logic                                                key_wr_en,
	output logic      [$clog2(QUEUE_DEPTH*KEYS_PER_ENTRY)-1:0]  key_wr_addr,
	output logic signed [dfkl_pkg::KEY_W-1:0]                   key_wr_data
);
	import dfkl_pkg::*;

	`include "dedup_fifo_with_key_lists_assert.svh"

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int KW = $clog2(KEYS_PER_ENTRY + 1);
	localparam int AW = $clog2(QUEUE_DEPTH * KEYS_PER_ENTRY);

	state_t state_q, state_d;

	// captured beat
	logic [OP_W-1:0]         op_q;
	logic [LETTER_W-1:0]     letter_q;
	logic signed [KEY_W-1:0] key_q;

	// queue pointers
	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] total_q, total_d;

	// scan bookkeeping
	logic [IW-1:0] scan_ptr_q;
	logic [CW-1:0] scan_left_q;
	logic          rd_valid_s1;
	logic [IW-1:0] rd_addr_s1;
	logic          found_q;
	logic [IW-1:0] slot_q;
	logic [KW-1:0] found_cnt_q;

	// result register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [KCNT_W-1:0]   out_cnt_q;

	// decode signals
	logic    out_free, hit_s1, scan_issue, scan_miss, commit;
	logic    do_push, do_append, do_pop;
	status_t res_status;
	logic [KW-1:0] res_cnt;
	logic [IW-1:0] wr_slot;
	logic [KW-1:0] wr_pos;

	// increment with wrap at the queue depth
	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
		logic [IW-1:0] r;
		if (v == IW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = v + 1'b1;
		end
		return r;
	endfunction

	// shared letter comparator on the registered read data
	assign out_free   = !out_valid_q || !out_stall;
	assign hit_s1     = rd_valid_s1 && (rd_letter == letter_q);
	assign scan_issue = (state_q == ST_SCAN) && !hit_s1 && (scan_left_q != '0);
	assign scan_miss  = (state_q == ST_SCAN) && !hit_s1 && (scan_left_q == '0)
		&& !rd_valid_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (op == OP_REMOVE || total_q == '0) begin
						state_d = ST_COMMIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit_s1 || scan_miss) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		commit   = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SCAN:   in_stall = 1'b1;
			ST_COMMIT: commit   = out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	// result decode for the captured beat
	always_comb begin
		do_push    = 1'b0;
		do_append  = 1'b0;
		do_pop     = 1'b0;
		res_status = STAT_EMPTY;
		res_cnt    = '0;
		if (op_q == OP_REMOVE) begin
			if (total_q != '0) begin
				do_pop     = 1'b1;
				res_status = STAT_REMOVED;
			end
		end else if (found_q) begin
			if (found_cnt_q >= KW'(KEYS_PER_ENTRY)) begin
				res_status = STAT_FULL;
				res_cnt    = found_cnt_q;
			end else begin
				do_append  = 1'b1;
				res_status = STAT_APPENDED;
				res_cnt    = found_cnt_q + 1'b1;
			end
		end else if (total_q >= CW'(QUEUE_DEPTH)) begin
			res_status = STAT_FULL;
		end else begin
			do_push    = 1'b1;
			res_status = STAT_NEW;
			res_cnt    = KW'(1);
		end
	end

	// entry count after the operation
	always_comb begin
		total_d = total_q;
		if (do_push) begin
			total_d = total_q + 1'b1;
		end else if (do_pop) begin
			total_d = total_q - 1'b1;
		end
	end

	// memory write and read ports
	assign wr_slot         = do_push ? tail_q : slot_q;
	assign wr_pos          = do_push ? KW'(0) : found_cnt_q;
	assign entry_wr.letter_en = commit && do_push;
	assign entry_wr.count_en  = commit && (do_push || do_append);
	assign entry_wr_addr   = wr_slot;
	assign entry_wr_letter = letter_q;
	assign entry_wr_count  = res_cnt;
	assign key_wr_en       = commit && (do_push || do_append);
	assign key_wr_addr     = AW'(wr_slot) * AW'(KEYS_PER_ENTRY) + AW'(wr_pos);
	assign key_wr_data     = key_q;
	assign rd_en           = scan_issue;
	assign rd_addr         = scan_ptr_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			total_q     <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= scan_issue;
			if (in_valid && !in_stall) begin
				found_q <= 1'b0;
			end else if (hit_s1 && state_q == ST_SCAN) begin
				found_q <= 1'b1;
			end
			if (commit) begin
				total_q <= total_d;
				if (do_push) begin
					tail_q <= wrap_inc(tail_q);
				end
				if (do_pop) begin
					head_q <= wrap_inc(head_q);
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q        <= op;
			letter_q    <= letter;
			key_q       <= key_value;
			scan_ptr_q  <= head_q;
			scan_left_q <= total_q;
		end else if (scan_issue) begin
			scan_ptr_q  <= wrap_inc(scan_ptr_q);
			scan_left_q <= scan_left_q - 1'b1;
		end
		rd_addr_s1 <= scan_ptr_q;
		if (hit_s1 && state_q == ST_SCAN) begin
			slot_q      <= rd_addr_s1;
			found_cnt_q <= rd_count;
		end
		if (commit) begin
			out_status_q <= res_status;
			out_len_q    <= LEN_W'(total_d);
			out_cnt_q    <= KCNT_W'(res_cnt);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign queue_length    = out_len_q;
	assign entry_key_count = out_cnt_q;

	// checks on the sequencer and queue pointers
	`DFKL_ASSERT_IMPLY(a_total_bound, clk, arst_n, 1'b1, total_q <= CW'(QUEUE_DEPTH))
	`DFKL_ASSERT_IMPLY(a_empty_ptrs, clk, arst_n, total_q == '0, head_q == tail_q)
	`DFKL_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_valid && !in_stall, state_q != ST_IDLE)
	`DFKL_ASSERT_NEXT(a_new_grows, clk, arst_n, commit && res_status == STAT_NEW, total_q == CW'($past(total_q) + 1'b1))

endmodule

`default_nettype wire

@@ sv/dedup_fifo_with_key_lists.sv @@
// channel  | signals                              | beat when
// ---------+--------------------------------------+---------------------------
// input    | in_valid, in_stall, op, letter,      | in_valid && !in_stall
//          | key_value                            |
// output   | out_valid, out_stall, status,        | out_valid && !out_stall
//          | queue_length, entry_key_count        |
//
// a remove, or an insert into an empty queue, goes from idle straight to the commit step
// an insert that matches the entry at queue position p stops its scan at that entry
// an insert with no match compares the letters of all n held entries: one letter
// compare per cycle through the single read port of the entry memory
// arst_n clears pointers, count and sequencer; the stores need no clearing pass
// a held result blocks only the commit step; scanning goes on meanwhile
`default_nettype none

module dedup_fifo_with_key_lists #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int KEYS_PER_ENTRY = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [dfkl_pkg::OP_W-1:0]         op,
	input  wire logic [dfkl_pkg::LETTER_W-1:0]     letter,
	input  wire logic signed [dfkl_pkg::KEY_W-1:0] key_value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [dfkl_pkg::STATUS_W-1:0]     status,
	output logic      [dfkl_pkg::LEN_W-1:0]        queue_length,
	output logic      [dfkl_pkg::KCNT_W-1:0]       entry_key_count
);
	import dfkl_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int KW = $clog2(KEYS_PER_ENTRY + 1);
	localparam int AW = $clog2(QUEUE_DEPTH * KEYS_PER_ENTRY);

	logic                    rd_en;
	logic [IW-1:0]           rd_addr;
	logic [LETTER_W-1:0]     rd_letter;
	logic [KW-1:0]           rd_count;
	entry_wr_t               entry_wr;
	logic [IW-1:0]           entry_wr_addr;
	logic [LETTER_W-1:0]     entry_wr_letter;
	logic [KW-1:0]           entry_wr_count;
	logic                    key_wr_en;
	logic [AW-1:0]           key_wr_addr;
	logic signed [KEY_W-1:0] key_wr_data;

	// sequencer with the shared letter comparator
	dfkl_ctrl #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.KEYS_PER_ENTRY(KEYS_PER_ENTRY)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.letter         (letter),
		.key_value      (key_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.queue_length   (queue_length),
		.entry_key_count(entry_key_count),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_letter      (rd_letter),
		.rd_count       (rd_count),
		.entry_wr       (entry_wr),
		.entry_wr_addr  (entry_wr_addr),
		.entry_wr_letter(entry_wr_letter),
		.entry_wr_count (entry_wr_count),
		.key_wr_en      (key_wr_en),
		.key_wr_addr    (key_wr_addr),
		.key_wr_data    (key_wr_data)
	);

	// letters and key counts per entry
	dfkl_entry_mem #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.KEYS_PER_ENTRY(KEYS_PER_ENTRY)
	) u_entry_mem (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_letter(rd_letter),
		.rd_count (rd_count),
		.wr       (entry_wr),
		.wr_addr  (entry_wr_addr),
		.wr_letter(entry_wr_letter),
		.wr_count (entry_wr_count)
	);

	// key lists
	dfkl_key_mem #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.KEYS_PER_ENTRY(KEYS_PER_ENTRY)
	) u_key_mem (
		.clk    (clk),
		.wr_en  (key_wr_en),
		.wr_addr(key_wr_addr),
		.wr_data(key_wr_data)
	);

endmodule

`default_nettype wire
